// ===== rtl/core/wuf_pkg.sv =====
package wuf_pkg;

  localparam int WUF_MAX_OBJECTS = 1024;

  // Fixed field widths of the request and result items.
  localparam int ELEM_W   = 10;
  localparam int OBJ_W    = 11;
  localparam int COUNT_W  = 11;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  // Microprogram steps.
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] S_IDLE    = 3'd0;
  localparam logic [STEP_W-1:0] S_START_P = 3'd1;
  localparam logic [STEP_W-1:0] S_WALK_P  = 3'd2;
  localparam logic [STEP_W-1:0] S_START_Q = 3'd3;
  localparam logic [STEP_W-1:0] S_WALK_Q  = 3'd4;
  localparam logic [STEP_W-1:0] S_DECIDE  = 3'd5;
  localparam logic [STEP_W-1:0] S_LINK    = 3'd6;
  localparam logic [STEP_W-1:0] S_DONE    = 3'd7;

  // Jump conditions.
  localparam logic [2:0] C_ALWAYS   = 3'd0;
  localparam logic [2:0] C_IN_REQ   = 3'd1;
  localparam logic [2:0] C_ERR      = 3'd2;
  localparam logic [2:0] C_ROOT     = 3'd3;
  localparam logic [2:0] C_SKIP     = 3'd4;
  localparam logic [2:0] C_OUT_FREE = 3'd5;

  // Read address select; any read also loads the walk pointer.
  localparam logic [1:0] A_NONE = 2'd0;
  localparam logic [1:0] A_P    = 2'd1;
  localparam logic [1:0] A_Q    = 2'd2;
  localparam logic [1:0] A_WALK = 2'd3;

  typedef struct packed {
    logic [2:0]        jcond;
    logic [STEP_W-1:0] target;
    logic              stay;    // hold the step when the condition is false
    logic [1:0]        asel;
    logic              cap_p;
    logic              cap_q;
    logic              link;
    logic              emit;
  } uword_t;

  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '0;
    unique case (step)
      S_IDLE: begin
        w.jcond = C_IN_REQ; w.target = S_START_P; w.stay = 1'b1;
      end
      S_START_P: begin
        w.jcond = C_ERR; w.target = S_DONE; w.asel = A_P;
      end
      S_WALK_P: begin
        w.jcond = C_ROOT; w.target = S_START_Q; w.stay = 1'b1;
        w.asel = A_WALK; w.cap_p = 1'b1;
      end
      S_START_Q: begin
        w.jcond = C_ALWAYS; w.target = S_WALK_Q; w.asel = A_Q;
      end
      S_WALK_Q: begin
        w.jcond = C_ROOT; w.target = S_DECIDE; w.stay = 1'b1;
        w.asel = A_WALK; w.cap_q = 1'b1;
      end
      S_DECIDE: begin
        w.jcond = C_SKIP; w.target = S_DONE;
      end
      S_LINK: begin
        w.jcond = C_ALWAYS; w.target = S_DONE; w.link = 1'b1;
      end
      S_DONE: begin
        w.jcond = C_OUT_FREE; w.target = S_IDLE; w.stay = 1'b1; w.emit = 1'b1;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/weighted_union_find.sv =====
// Weighted quick-union engine. Each request on in_ carries a command in
// in_tuser (0 = union, 1 = connected query) and elements p and q in in_tdata;
// it returns one result on out_. The block handles one request at a time and
// walks parent links through a single-read memory, one hop per cycle. The
// depth of p or q in its tree, and so the length of its walk, is at most
// log2 of the element count; a union that merges adds a link step, and a
// request with an index error skips the walks and goes straight to its
// result. The engine returns to idle when the result is registered and only
// then takes the next request. While an earlier result still waits for the
// receiver, the engine holds in its last step. After reset and after every
// configuration write the tables are rewritten as singletons in a clearing
// pass over all MAX_OBJECTS entries, during which no request is accepted.
module weighted_union_find import wuf_pkg::*; #(
  parameter int MAX_OBJECTS = WUF_MAX_OBJECTS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [9:0] elem_p, [19:10] elem_q, [23:20] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] cmd
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] were_connected, [1] merged, [12:2] component_count, [13] index_error,
  // [15:14] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [OBJ_W-1:0]       cfg_data
);

  localparam int IDX_W = $clog2(MAX_OBJECTS);
  localparam int CNT_W = $clog2(MAX_OBJECTS + 1);
  localparam int CMP_W = (CNT_W > OBJ_W) ? CNT_W : OBJ_W;
  localparam int RESET_N = (WUF_MAX_OBJECTS > MAX_OBJECTS) ? MAX_OBJECTS : WUF_MAX_OBJECTS;

  logic [STEP_W-1:0] upc_r, upc_nxt;
  uword_t            uw;

  logic             cmd_r;
  logic             err_r;
  logic [IDX_W-1:0] p_r, q_r, x_r;
  logic [IDX_W-1:0] rp_r, rq_r;
  logic [CNT_W-1:0] sp_r, sq_r;
  logic             merged_r;
  logic [CNT_W-1:0] n_eff_r, n_eff_nxt;
  logic [CNT_W-1:0] merge_r;

  logic             out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic             mem_busy;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] rd_parent;
  logic [CNT_W-1:0] rd_size;
  logic [IDX_W-1:0] link_child, link_root;
  logic [CNT_W-1:0] link_size;

  logic             in_req, cfg_req, out_free, cond, is_root;
  logic [ELEM_W-1:0] in_p, in_q;
  logic             in_err;
  logic             connected;

  assign in_p    = in_tdata[ELEM_W-1:0];
  assign in_q    = in_tdata[2*ELEM_W-1:ELEM_W];
  assign in_tready = (upc_r == S_IDLE) && !mem_busy;
  assign in_req  = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_req = cfg_valid;
  assign out_free = !out_valid_r || out_tready;
  assign uw      = ucode(upc_r);
  assign is_root = (rd_parent == x_r);
  assign connected = !err_r && (rp_r == rq_r);

  assign in_err = (CMP_W'(in_p) >= CMP_W'(n_eff_r)) || (CMP_W'(in_q) >= CMP_W'(n_eff_r));

  // Effective count is the written value clamped into 1..MAX_OBJECTS.
  always_comb begin
    if (cfg_data == '0) begin
      n_eff_nxt = CNT_W'(1);
    end else if (CMP_W'(cfg_data) > CMP_W'(MAX_OBJECTS)) begin
      n_eff_nxt = CNT_W'(MAX_OBJECTS);
    end else begin
      n_eff_nxt = CNT_W'(cfg_data);
    end
  end

  always_comb begin
    unique case (uw.jcond)
      C_ALWAYS:   cond = 1'b1;
      C_IN_REQ:   cond = in_req;
      C_ERR:      cond = err_r;
      C_ROOT:     cond = is_root;
      C_SKIP:     cond = cmd_r || (rp_r == rq_r);
      C_OUT_FREE: cond = out_free;
      default:    cond = 1'b1;
    endcase
  end

  always_comb begin
    if (cond) begin
      upc_nxt = uw.target;
    end else if (uw.stay) begin
      upc_nxt = upc_r;
    end else begin
      upc_nxt = upc_r + 1'b1;
    end
  end

  always_comb begin
    unique case (uw.asel)
      A_P:     rd_addr = p_r;
      A_Q:     rd_addr = q_r;
      A_WALK:  rd_addr = rd_parent;
      default: rd_addr = x_r;
    endcase
  end

  // The smaller tree goes under the larger; on a tie q's root goes under p's.
  always_comb begin
    if (sp_r < sq_r) begin
      link_child = rp_r;
      link_root  = rq_r;
    end else begin
      link_child = rq_r;
      link_root  = rp_r;
    end
    link_size = sp_r + sq_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= S_IDLE;
      out_valid_r <= 1'b0;
      n_eff_r     <= CNT_W'(RESET_N);
      merge_r     <= '0;
    end else begin
      upc_r <= upc_nxt;
      if (cfg_req) begin
        n_eff_r <= n_eff_nxt;
        merge_r <= '0;
      end else if (uw.link) begin
        merge_r <= merge_r + 1'b1;
      end
      if (uw.emit && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_req) begin
      cmd_r    <= in_tuser;
      p_r      <= IDX_W'(in_p);
      q_r      <= IDX_W'(in_q);
      err_r    <= in_err;
      merged_r <= 1'b0;
    end else if (uw.link) begin
      merged_r <= 1'b1;
    end
    if (uw.asel != A_NONE) begin
      x_r <= rd_addr;
    end
    if (uw.cap_p && is_root) begin
      rp_r <= x_r;
      sp_r <= rd_size;
    end
    if (uw.cap_q && is_root) begin
      rq_r <= x_r;
      sq_r <= rd_size;
    end
    if (uw.emit && out_free) begin
      out_data_r <= {{(OUT_TDATA_W - COUNT_W - 3){1'b0}}, err_r,
                     COUNT_W'(n_eff_r - merge_r), merged_r, connected};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  wuf_mem #(
    .MAX_OBJECTS (MAX_OBJECTS),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_mem (
    .clk         (clk),
    .rst_n       (rst_n),
    .clear_start (cfg_req),
    .busy        (mem_busy),
    .rd_addr     (rd_addr),
    .rd_parent   (rd_parent),
    .rd_size     (rd_size),
    .link_en     (uw.link),
    .link_child  (link_child),
    .link_root   (link_root),
    .link_size   (link_size)
  );

endmodule

// ===== rtl/core/wuf_mem.sv =====
module wuf_mem import wuf_pkg::*; #(
  parameter int MAX_OBJECTS = WUF_MAX_OBJECTS,
  parameter int IDX_W       = $clog2(MAX_OBJECTS),
  parameter int CNT_W       = $clog2(MAX_OBJECTS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clear_start,
  output logic             busy,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [IDX_W-1:0] rd_parent,
  output logic [CNT_W-1:0] rd_size,
  input  logic             link_en,
  input  logic [IDX_W-1:0] link_child,
  input  logic [IDX_W-1:0] link_root,
  input  logic [CNT_W-1:0] link_size
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_OBJECTS - 1);

  logic [IDX_W-1:0] parent_mem [MAX_OBJECTS];
  logic [CNT_W-1:0] size_mem   [MAX_OBJECTS];

  logic             clr_active_r, clr_active_nxt;
  logic [IDX_W-1:0] clr_idx_r, clr_idx_nxt;

  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_idx_nxt    = clr_idx_r;
    if (clear_start) begin
      clr_active_nxt = 1'b1;
      clr_idx_nxt    = '0;
    end else if (clr_active_r) begin
      if (clr_idx_r == LAST_IDX) begin
        clr_active_nxt = 1'b0;
      end else begin
        clr_idx_nxt = clr_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_idx_r    <= clr_idx_nxt;
    end
  end

  assign busy = clr_active_r;

  // The clearing pass rewrites every entry as a singleton root.
  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      parent_mem[clr_idx_r] <= clr_idx_r;
      size_mem[clr_idx_r]   <= CNT_W'(1);
    end else if (link_en) begin
      parent_mem[link_child] <= link_root;
      size_mem[link_root]    <= link_size;
    end
  end

  always_ff @(posedge clk) begin
    rd_parent <= parent_mem[rd_addr];
    rd_size   <= size_mem[rd_addr];
  end

endmodule
